[hw/rtl/sync_length_checksum_deframer_top_defines.svh]
// Assertion helpers for the deframer.
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_TOP_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTH
`define SLCD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
`define SLCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define SLCD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SLCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/slcd_pkg.sv]
package slcd_pkg;

  localparam logic [7:0]  SyncFirst    = 8'h55;
  localparam logic [7:0]  SyncSecond   = 8'hAA;

  localparam logic [10:0] PosHunt      = 11'd0;
  localparam logic [10:0] PosSync2     = 11'd1;
  localparam logic [10:0] PosSeqHi     = 11'd3;
  localparam logic [10:0] PosSeqLo     = 11'd4;
  localparam logic [10:0] PosCmd       = 11'd5;
  localparam logic [10:0] PosLenHi     = 11'd6;
  localparam logic [10:0] PosLenLo     = 11'd7;
  localparam logic [10:0] HeaderBytes  = 11'd8;

  localparam logic [10:0] LimitCeiling = 11'd1024;
  localparam logic [10:0] LimitReset   = 11'd512;
  localparam logic [16:0] FrameOverhead = 17'd9;

  localparam logic [1:0]  CfgAddrMaxFrame = 2'd0;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [9:0]  payload_index;
    logic        frame_end;
    logic        checksum_ok;
    logic [15:0] sequence_number;
    logic [7:0]  command_code;
    logic [9:0]  payload_length;
  } slcd_result_t;

endpackage

[hw/rtl/slcd_parse.sv]
module slcd_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [10:0]           max_frame_bytes_i,
  output logic                  res_valid_o,
  output slcd_pkg::slcd_result_t res_o
);
  import slcd_pkg::*;

  logic [10:0] pos_q, pos_d;
  logic [15:0] seq_q, seq_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [9:0]  len_q, len_d;
  logic [7:0]  sum_q, sum_d;

  logic [7:0]  sum_add;
  logic [10:0] limit_sat;
  logic [16:0] frame_total;
  logic [10:0] pay_idx;

  assign sum_add     = sum_q + rx_byte_i;
  assign limit_sat   = (max_frame_bytes_i > LimitCeiling) ? LimitCeiling : max_frame_bytes_i;
  assign frame_total = {1'b0, len_hi_q, rx_byte_i} + FrameOverhead;
  assign pay_idx     = pos_q - HeaderBytes;

  always_comb begin
    pos_d    = pos_q;
    seq_d    = seq_q;
    cmd_d    = cmd_q;
    len_hi_d = len_hi_q;
    len_d    = len_q;
    sum_d    = sum_q;

    res_valid_o           = 1'b0;
    res_o.data_byte       = rx_byte_i;
    res_o.payload_index   = '0;
    res_o.frame_end       = 1'b0;
    res_o.checksum_ok     = 1'b0;
    res_o.sequence_number = seq_q;
    res_o.command_code    = cmd_q;
    res_o.payload_length  = len_q;

    if (pos_q == PosHunt) begin
      if (rx_byte_i == SyncFirst) begin
        pos_d = PosSync2;
        sum_d = SyncFirst;
      end
    end else if (pos_q == PosSync2) begin
      if (rx_byte_i == SyncSecond) begin
        pos_d = pos_q + 11'd1;
        sum_d = sum_add;
      end else if (rx_byte_i == SyncFirst) begin
        sum_d = SyncFirst;
      end else begin
        pos_d = PosHunt;
        sum_d = '0;
      end
    end else if (pos_q < HeaderBytes) begin
      pos_d = pos_q + 11'd1;
      sum_d = sum_add;
      case (pos_q)
        PosSeqHi: seq_d[15:8] = rx_byte_i;
        PosSeqLo: seq_d[7:0]  = rx_byte_i;
        PosCmd:   cmd_d       = rx_byte_i;
        PosLenHi: len_hi_d    = rx_byte_i;
        PosLenLo: begin
          len_d = {len_hi_q[1:0], rx_byte_i};
          if (frame_total > {6'd0, limit_sat}) begin
            // drop oversized frame
            pos_d = PosHunt;
            sum_d = '0;
          end
        end
        default: ;
      endcase
    end else begin
      res_valid_o = 1'b1;
      if (pay_idx < {1'b0, len_q}) begin
        res_o.payload_index = pay_idx[9:0];
        pos_d = pos_q + 11'd1;
        sum_d = sum_add;
      end else begin
        res_o.frame_end   = 1'b1;
        res_o.checksum_ok = (sum_q == rx_byte_i);
        pos_d = PosHunt;
        sum_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosHunt;
      seq_q    <= '0;
      cmd_q    <= '0;
      len_hi_q <= '0;
      len_q    <= '0;
      sum_q    <= '0;
    end else if (accept_i) begin
      pos_q    <= pos_d;
      seq_q    <= seq_d;
      cmd_q    <= cmd_d;
      len_hi_q <= len_hi_d;
      len_q    <= len_d;
      sum_q    <= sum_d;
    end
  end

endmodule

[hw/rtl/sync_length_checksum_deframer_top.sv]
// Byte-serial deframer: hunts for the sync pair 0x55 0xAA, reads version, sequence,
// command and length, forwards each payload byte as a result, and closes the frame
// with a result carrying the checksum byte and its verdict (8-bit sum of all earlier
// frame bytes). Payload leaves before the verdict, so discard it when checksum_ok is 0.
// Frames longer than max_frame_bytes (capped at 1024) are dropped at the length byte.
// A byte is taken every unstalled cycle; a payload or checksum result appears in the
// output register in the cycle after acceptance. The input stalls only while that
// register holds a result the output side is stalling. No clearing pass is needed after reset.
`include "sync_length_checksum_deframer_top_defines.svh"

module sync_length_checksum_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic [9:0]  payload_index_o,
  output logic        frame_end_o,
  output logic        checksum_ok_o,
  output logic [15:0] sequence_number_o,
  output logic [7:0]  command_code_o,
  output logic [9:0]  payload_length_o
);
  import slcd_pkg::*;

  logic [10:0]  max_frame_q;
  logic         out_free;
  logic         in_acc;
  logic         par_valid;
  slcd_result_t par_res;
  logic         out_valid_q, out_valid_d;
  slcd_result_t out_q;

  assign pready = 1'b1;
  assign prdata = (paddr == CfgAddrMaxFrame) ? {21'd0, max_frame_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= LimitReset;
    end else if (psel && penable && pwrite && pready) begin
      max_frame_q <= pwdata[10:0];
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_free;
  assign in_acc     = in_valid_i && out_free;

  slcd_parse u_parse (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (in_acc),
    .rx_byte_i         (rx_byte_i),
    .max_frame_bytes_i (max_frame_q),
    .res_valid_o       (par_valid),
    .res_o             (par_res)
  );

  assign out_valid_d = out_free ? (in_acc && par_valid) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && par_valid) begin
      out_q <= par_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign data_byte_o       = out_q.data_byte;
  assign payload_index_o   = out_q.payload_index;
  assign frame_end_o       = out_q.frame_end;
  assign checksum_ok_o     = out_q.checksum_ok;
  assign sequence_number_o = out_q.sequence_number;
  assign command_code_o    = out_q.command_code;
  assign payload_length_o  = out_q.payload_length;

  `SLCD_ASSERT_IMPLY(a_index_in_payload, clk_i, rst_ni, out_valid_o && !frame_end_o, payload_index_o < payload_length_o)
  `SLCD_ASSERT_IMPLY(a_length_fits, clk_i, rst_ni, out_valid_o, payload_length_o <= 10'd1015)
  `SLCD_ASSERT_IMPLY(a_verdict_on_end, clk_i, rst_ni, out_valid_o && checksum_ok_o, frame_end_o)
  `SLCD_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, in_acc && par_valid, out_valid_o)

endmodule
